>>> sv/tsg_pkg.sv
package tsg_pkg;
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam logic [1:0] EV_PRESS    = 2'd0;
  localparam logic [1:0] EV_PRESSING = 2'd1;
  localparam logic [1:0] EV_RELEASE  = 2'd2;

  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;

  localparam logic [2:0] CFG_EDGE_X  = 3'd0;
  localparam logic [2:0] CFG_EDGE_Y  = 3'd1;
  localparam logic [2:0] CFG_MOVE_X  = 3'd2;
  localparam logic [2:0] CFG_MOVE_Y  = 3'd3;
  localparam logic [2:0] CFG_SLOPE   = 3'd4;
  localparam logic [2:0] CFG_SHORT   = 3'd5;
  localparam logic [2:0] CFG_SLOW    = 3'd6;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQRT  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SLOPE = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;
endpackage

>>> sv/touch_swipe_gesture_recognizer.sv
// Touch swipe gesture recognizer.
// Input channel: in_valid/in_stall with touched, pos_x, pos_y, now_ms. One
// beat is one panel sample. Output channel: out_valid/out_stall with one
// result beat per sample that is touched or ends an active gesture; an idle
// untouched sample yields no beat.
// Config: cfg_we, cfg_index, cfg_data; write only while idle.
// A press beat goes through ST_OUT only. A sample with no movement goes
// through ST_FIN and ST_OUT. A moving sample first runs ST_SQRT, a bit-serial
// square root (2 radicand bits per root digit), then ST_DIV, a restoring
// divide (one quotient bit per step), then ST_SLOPE, a shift-add slope
// multiply and the direction pick, and then ST_FIN and ST_OUT.
// One sample at a time: in_stall stays high from acceptance until the result
// beat is taken. When the receiver stalls, the result beat holds.
// Reset (rst_n low, synchronous) clears the gesture and loads the register
// defaults; no beat is pending after reset.
module touch_swipe_gesture_recognizer
  import tsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_touched,
  input  logic [9:0]  in_pos_x,
  input  logic [9:0]  in_pos_y,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [9:0]  out_start_x,
  output logic [9:0]  out_start_y,
  output logic [9:0]  out_stop_x,
  output logic [9:0]  out_stop_y,
  output logic [3:0]  out_start_area,
  output logic [3:0]  out_stop_area,
  output logic [2:0]  out_direction,
  output logic [31:0] out_duration_ms,
  output logic [14:0] out_distance_px,
  output logic [15:0] out_speed,
  output logic [1:0]  out_qualifiers,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [10:0] ewx_r, ewy_r, mmx_r, mmy_r;
  logic [15:0] slope_r, short_r, slowl_r;

  logic        active_r;
  logic [31:0] begin_r;
  logic [9:0]  fx_r, fy_r, lx_r, ly_r;
  logic [3:0]  fa_r, la_r;
  logic [2:0]  hdir_r;
  logic [14:0] hdist_r;
  logic [15:0] hspd_r;
  logic        hslow_r;

  logic [2:0]  st_r;
  logic        touch_r;
  logic [31:0] dur_r;
  logic [10:0] dx_r, dy_r;
  logic [9:0]  adx_r, ady_r;
  logic [29:0] rad_r;
  logic [15:0] root_r;
  logic [15:0] rem_r;
  logic [4:0]  cnt_r;
  logic [32:0] drem_r;
  logic [18:0] dq_r;
  logic [18:0] dn_r;
  logic [25:0] prod_r;
  logic [15:0] mq_r;

  logic [1:0]  o_kind_r;
  logic [2:0]  o_dir_r;
  logic [31:0] o_dur_r;
  logic [14:0] o_dist_r;
  logic [15:0] o_spd_r;
  logic [1:0]  o_q_r;
  logic        ov_r;

  function automatic logic [3:0] edge_mask(logic [9:0] x, logic [9:0] y,
                                           logic [10:0] ewx, logic [10:0] ewy);
    logic signed [12:0] hy, wx;
    logic [3:0] m;
    hy = 13'(SCREEN_HEIGHT) - $signed({3'b0, y});
    wx = 13'(SCREEN_WIDTH) - $signed({3'b0, x});
    m[0] = {1'b0, y} < ewy;
    m[1] = hy < $signed({2'b0, ewy});
    m[2] = {1'b0, x} < ewx;
    m[3] = wx < $signed({2'b0, ewx});
    return m;
  endfunction

  logic [18:0] trial;
  logic [32:0] dtrial;
  logic [14:0] dist_fin;
  logic [15:0] spd_fin;
  assign trial  = {1'b0, rem_r, rad_r[29:28]} - {2'b0, root_r[14:0], 2'b01};
  assign dtrial = {drem_r[31:0], dn_r[18]} - {1'b0, dur_r};
  assign dist_fin = root_r[14:0];

  assign in_stall  = (st_r != ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_event_kind  = o_kind_r;
  assign out_start_x     = fx_r;
  assign out_start_y     = fy_r;
  assign out_stop_x      = lx_r;
  assign out_stop_y      = ly_r;
  assign out_start_area  = fa_r;
  assign out_stop_area   = la_r;
  assign out_direction   = o_dir_r;
  assign out_duration_ms = o_dur_r;
  assign out_distance_px = o_dist_r;
  assign out_speed       = o_spd_r;
  assign out_qualifiers  = o_q_r;

  logic [2:0] dir_new;
  logic       vert;
  always_comb begin
    vert = (dx_r == '0) || ({ady_r, 8'h00} > prod_r[17:0]) || (prod_r[25:18] != '0 && 1'b0);
    dir_new = hdir_r;
    if (vert) begin
      if ($signed(dy_r) > $signed({1'b0, mmy_r[9:0]}) && mmy_r[10] == 1'b0) dir_new = DIR_DOWN;
      else if ($signed(dy_r) < -$signed({1'b0, mmy_r[9:0]}) && mmy_r[10] == 1'b0)
        dir_new = DIR_UP;
    end else begin
      if ($signed(dx_r) > $signed({1'b0, mmx_r[9:0]}) && mmx_r[10] == 1'b0) dir_new = DIR_RIGHT;
      else if ($signed(dx_r) < -$signed({1'b0, mmx_r[9:0]}) && mmx_r[10] == 1'b0)
        dir_new = DIR_LEFT;
    end
    spd_fin = (dq_r[18:16] != '0) ? 16'hFFFF : dq_r[15:0];
    if (dur_r == '0) spd_fin = 16'hFFFF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ewx_r <= 11'd32; ewy_r <= 11'd24; mmx_r <= 11'd53; mmy_r <= 11'd40;
      slope_r <= 16'd256; short_r <= 16'd220; slowl_r <= 16'd154;
      active_r <= 1'b0; begin_r <= '0; fx_r <= '0; fy_r <= '0; lx_r <= '0; ly_r <= '0;
      fa_r <= '0; la_r <= '0; hdir_r <= DIR_NONE; hdist_r <= '0; hspd_r <= '0;
      hslow_r <= 1'b0; st_r <= ST_IDLE; ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_EDGE_X: ewx_r   <= cfg_data[10:0];
          CFG_EDGE_Y: ewy_r   <= cfg_data[10:0];
          CFG_MOVE_X: mmx_r   <= cfg_data[10:0];
          CFG_MOVE_Y: mmy_r   <= cfg_data[10:0];
          CFG_SLOPE:  slope_r <= cfg_data;
          CFG_SHORT:  short_r <= cfg_data;
          CFG_SLOW:   slowl_r <= cfg_data;
          default: ;
        endcase
      end
      if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
        if (o_kind_r == EV_RELEASE) begin
          active_r <= 1'b0; begin_r <= '0; fx_r <= '0; fy_r <= '0; lx_r <= '0;
          ly_r <= '0; fa_r <= '0; la_r <= '0; hdir_r <= DIR_NONE; hdist_r <= '0;
          hspd_r <= '0; hslow_r <= 1'b0;
        end
      end
      case (st_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            touch_r <= in_touched;
            if (in_touched) begin
              lx_r <= in_pos_x; ly_r <= in_pos_y;
              la_r <= edge_mask(in_pos_x, in_pos_y, ewx_r, ewy_r);
            end
            if (!active_r && in_touched) begin
              active_r <= 1'b1; begin_r <= in_now_ms; fx_r <= in_pos_x; fy_r <= in_pos_y;
              fa_r <= edge_mask(in_pos_x, in_pos_y, ewx_r, ewy_r);
              hdir_r <= DIR_NONE; hdist_r <= '0; hspd_r <= '0; hslow_r <= 1'b0;
              o_kind_r <= EV_PRESS; o_dir_r <= DIR_NONE; o_dur_r <= '0;
              o_dist_r <= '0; o_spd_r <= '0; o_q_r <= '0;
              st_r <= ST_OUT;
            end else if (active_r) begin
              dur_r <= in_now_ms - begin_r;
              st_r <= ST_FIN;
              cnt_r <= 5'd0;
              if (in_touched) begin
                dx_r <= {1'b0, in_pos_x} - {1'b0, fx_r};
                dy_r <= {1'b0, in_pos_y} - {1'b0, fy_r};
                if (in_pos_x != fx_r || in_pos_y != fy_r) st_r <= ST_SQRT;
              end else begin
                dx_r <= {1'b0, lx_r} - {1'b0, fx_r};
                dy_r <= {1'b0, ly_r} - {1'b0, fy_r};
                if (lx_r != fx_r || ly_r != fy_r) st_r <= ST_SQRT;
              end
              adx_r <= '0; ady_r <= '0; rad_r <= '0; root_r <= '0; rem_r <= '0;
            end
          end
        end
        ST_SQRT: begin
          // first step builds |dx|,|dy|; next two steps form the square terms; then 15 root digits
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd0) begin
            adx_r <= dx_r[10] ? 10'(-dx_r) : dx_r[9:0];
            ady_r <= dy_r[10] ? 10'(-dy_r) : dy_r[9:0];
          end else if (cnt_r == 5'd1) begin
            rad_r <= {10'(0), 20'(adx_r * adx_r)};
          end else if (cnt_r == 5'd2) begin
            rad_r <= {1'b0, (21'(rad_r[19:0]) + 21'(ady_r * ady_r)), 8'h00};
          end else begin
            if (!trial[18]) begin
              rem_r  <= trial[15:0];
              root_r <= {root_r[14:0], 1'b1};
            end else begin
              rem_r  <= {rem_r[13:0], rad_r[29:28]};
              root_r <= {root_r[14:0], 1'b0};
            end
            rad_r <= {rad_r[27:0], 2'b00};
            if (cnt_r == 5'd17) begin
              st_r <= ST_DIV;
              cnt_r <= 5'd0;
            end
          end
        end
        ST_DIV: begin
          if (cnt_r == 5'd0) begin
            hdist_r <= dist_fin;
            dn_r <= {dist_fin, 4'h0};
            drem_r <= '0; dq_r <= '0;
            cnt_r <= 5'd1;
          end else begin
            if (!dtrial[32]) begin
              drem_r <= dtrial; dq_r <= {dq_r[17:0], 1'b1};
            end else begin
              drem_r <= {drem_r[31:0], dn_r[18]}; dq_r <= {dq_r[17:0], 1'b0};
            end
            dn_r <= {dn_r[17:0], 1'b0};
            cnt_r <= cnt_r + 5'd1;
            if (cnt_r == 5'd19) begin
              st_r <= ST_SLOPE; cnt_r <= 5'd0; prod_r <= '0; mq_r <= slope_r;
            end
          end
        end
        ST_SLOPE: begin
          if (cnt_r == 5'd0) begin
            hspd_r  <= spd_fin;
            hslow_r <= spd_fin < slowl_r;
          end
          if (cnt_r < 5'd16) begin
            prod_r <= {prod_r[24:0], 1'b0} + (mq_r[15] ? 26'(adx_r) : 26'd0);
            mq_r <= {mq_r[14:0], 1'b0};
            cnt_r <= cnt_r + 5'd1;
          end else begin
            if (prod_r[25:18] == '0) hdir_r <= dir_new;
            else if (!((dx_r == '0))) begin
              if ($signed(dx_r) > $signed({1'b0, mmx_r[9:0]}) && !mmx_r[10])
                hdir_r <= DIR_RIGHT;
              else if ($signed(dx_r) < -$signed({1'b0, mmx_r[9:0]}) && !mmx_r[10])
                hdir_r <= DIR_LEFT;
            end else hdir_r <= dir_new;
            st_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          o_kind_r <= touch_r ? EV_PRESSING : EV_RELEASE;
          o_dir_r  <= hdir_r; o_dur_r <= dur_r; o_dist_r <= hdist_r; o_spd_r <= hspd_r;
          o_q_r    <= {hslow_r, (dur_r < {16'h0, short_r})};
          st_r <= ST_OUT;
        end
        ST_OUT: begin
          ov_r <= 1'b1;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> sv/tsg_checker.sv
module tsg_checker
  import tsg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_event_kind,
  input logic [2:0]  out_direction,
  input logic [14:0] out_distance_px
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind))
    else $error("stalled beat changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_kind != 2'd3) else $error("bad event kind");
  a_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_PRESS |-> out_direction == DIR_NONE &&
    out_distance_px == '0) else $error("press beat carries motion");
endmodule

bind touch_swipe_gesture_recognizer tsg_checker u_tsg_checker (.*);

>>> verif/gesture_checker.sv
`timescale 1ns / 100ps

module gesture_checker
  import tsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_touched,
  input  logic [9:0]  in_pos_x,
  input  logic [9:0]  in_pos_y,
  input  logic [31:0] in_now_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_event_kind,
  input  logic [9:0]  out_start_x,
  input  logic [9:0]  out_start_y,
  input  logic [9:0]  out_stop_x,
  input  logic [9:0]  out_stop_y,
  input  logic [3:0]  out_start_area,
  input  logic [3:0]  out_stop_area,
  input  logic [2:0]  out_direction,
  input  logic [31:0] out_duration_ms,
  input  logic [14:0] out_distance_px,
  input  logic [15:0] out_speed,
  input  logic [1:0]  out_qualifiers,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          event_count
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  sx;
    logic [9:0]  sy;
    logic [9:0]  ex;
    logic [9:0]  ey;
    logic [3:0]  sarea;
    logic [3:0]  earea;
    logic [2:0]  dir;
    logic [31:0] dur;
    logic [14:0] dlen;
    logic [15:0] spd;
    logic [1:0]  qual;
  } gesture_event_t;

  gesture_event_t event_q[$];

  logic [10:0] edge_x, edge_y, move_x, move_y;
  logic [15:0] slope_lim, short_ms, slow_lim;

  logic        active;
  logic [31:0] t0;
  logic [9:0]  x0, y0, x1, y1;
  logic [3:0]  area0, area1;
  logic [2:0]  dir_h;
  logic [14:0] dist_h;
  logic [15:0] spd_h;
  logic        slow_h;

  assign pending = event_q.size();

  function automatic logic [3:0] area_of(logic [9:0] x, logic [9:0] y);
    int xs, ys;
    logic [3:0] m;
    xs = x;
    ys = y;
    m = '0;
    if (ys < int'(edge_y)) m[0] = 1'b1;
    if (SCREEN_HEIGHT - ys < int'(edge_y)) m[1] = 1'b1;
    if (xs < int'(edge_x)) m[2] = 1'b1;
    if (SCREEN_WIDTH - xs < int'(edge_x)) m[3] = 1'b1;
    return m;
  endfunction

  function automatic logic [31:0] root_floor(logic [31:0] v);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic clear_gesture();
    active = 0; t0 = 0; x0 = 0; y0 = 0; x1 = 0; y1 = 0;
    area0 = 0; area1 = 0; dir_h = DIR_NONE; dist_h = 0; spd_h = 0; slow_h = 0;
  endtask

  task automatic predict_gesture(logic touch, logic [9:0] px, logic [9:0] py,
                                 logic [31:0] now);
    gesture_event_t e;
    int dx, dy;
    longint unsigned adx, ady, q;
    logic vert;
    e = '0;
    if (touch) begin
      x1 = px; y1 = py; area1 = area_of(px, py);
    end
    if (!active && !touch) return;
    if (!active) begin
      active = 1; t0 = now; x0 = px; y0 = py; area0 = area1;
      dir_h = DIR_NONE; dist_h = 0; spd_h = 0; slow_h = 0;
      e.kind = EV_PRESS;
    end else begin
      dx = int'(x1) - int'(x0);
      dy = int'(y1) - int'(y0);
      e.dur = now - t0;
      if (e.dur < short_ms) e.qual[0] = 1'b1;
      if (dx != 0 || dy != 0) begin
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        dist_h = 15'(root_floor(32'((adx * adx + ady * ady) * 256)));
        if (e.dur == 0) begin
          spd_h = 16'hFFFF;
        end else begin
          q = (64'(dist_h) * 16) / e.dur;
          spd_h = q > 64'hFFFF ? 16'hFFFF : 16'(q);
        end
        slow_h = spd_h < slow_lim;
        vert = (dx == 0) || (ady * 256 > 64'(slope_lim) * adx);
        if (vert) begin
          if (dy > int'(move_y)) dir_h = DIR_DOWN;
          else if (dy < -int'(move_y)) dir_h = DIR_UP;
        end else begin
          if (dx > int'(move_x)) dir_h = DIR_RIGHT;
          else if (dx < -int'(move_x)) dir_h = DIR_LEFT;
        end
      end
      if (slow_h) e.qual[1] = 1'b1;
      e.kind = touch ? EV_PRESSING : EV_RELEASE;
      e.dir = dir_h;
      e.dlen = dist_h;
      e.spd = spd_h;
    end
    e.sx = x0; e.sy = y0; e.ex = x1; e.ey = y1; e.sarea = area0; e.earea = area1;
    event_q.push_back(e);
    if (e.kind == EV_RELEASE) clear_gesture();
  endtask

  gesture_event_t seen, want;

  initial begin
    fail_count = 0;
    event_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      edge_x = 32; edge_y = 24; move_x = 53; move_y = 40;
      slope_lim = 256; short_ms = 220; slow_lim = 154;
      clear_gesture();
      event_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_EDGE_X: edge_x = cfg_data[10:0];
          CFG_EDGE_Y: edge_y = cfg_data[10:0];
          CFG_MOVE_X: move_x = cfg_data[10:0];
          CFG_MOVE_Y: move_y = cfg_data[10:0];
          CFG_SLOPE:  slope_lim = cfg_data;
          CFG_SHORT:  short_ms = cfg_data;
          CFG_SLOW:   slow_lim = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen = {out_event_kind, out_start_x, out_start_y, out_stop_x, out_stop_y,
                out_start_area, out_stop_area, out_direction, out_duration_ms,
                out_distance_px, out_speed, out_qualifiers};
        event_count++;
        if (event_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %p", seen);
        end else begin
          want = event_q.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch\n  exp %p\n  got %p", want, seen);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_gesture(in_touched, in_pos_x, in_pos_y, in_now_ms);
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tsg_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 20000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_touched;
  logic [9:0]  in_pos_x, in_pos_y;
  logic [31:0] in_now_ms;
  logic        out_valid, out_stall;
  logic [1:0]  out_event_kind;
  logic [9:0]  out_start_x, out_start_y, out_stop_x, out_stop_y;
  logic [3:0]  out_start_area, out_stop_area;
  logic [2:0]  out_direction;
  logic [31:0] out_duration_ms;
  logic [14:0] out_distance_px;
  logic [15:0] out_speed;
  logic [1:0]  out_qualifiers;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count, pending, event_count;
  int beats_sent, gestures, burst_left, idle_cycles;
  logic [31:0] clock_ms;

  touch_swipe_gesture_recognizer i_dut (.*);
  gesture_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    repeat (3000) begin
      out_stall <= ($urandom_range(0, 3) == 0);
      @(posedge clk);
    end
    out_stall <= 1'b1;
    repeat (1500) @(posedge clk);
    forever begin
      case ($urandom_range(0, 2))
        0: repeat ($urandom_range(20, 200)) begin
             out_stall <= 1'b0;
             @(posedge clk);
           end
        1: repeat ($urandom_range(20, 200)) begin
             out_stall <= ($urandom_range(0, 1) == 0);
             @(posedge clk);
           end
        default: repeat ($urandom_range(1, 4)) begin
             out_stall <= 1'b1;
             repeat ($urandom_range(1, 40)) @(posedge clk);
             out_stall <= 1'b0;
             @(posedge clk);
           end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_beat(logic touch, int x, int y, logic [31:0] now);
    in_valid   <= 1'b1;
    in_touched <= touch;
    in_pos_x   <= 10'(x);
    in_pos_y   <= 10'(y);
    in_now_ms  <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 90)) @(posedge clk);
      end
    end
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_all(int ex, int ey, int mx, int my, int sl, int sh, int sw);
    quiesce();
    write_cfg(CFG_EDGE_X, 16'(ex));
    write_cfg(CFG_EDGE_Y, 16'(ey));
    write_cfg(CFG_MOVE_X, 16'(mx));
    write_cfg(CFG_MOVE_Y, 16'(my));
    write_cfg(CFG_SLOPE, 16'(sl));
    write_cfg(CFG_SHORT, 16'(sh));
    write_cfg(CFG_SLOW, 16'(sw));
    write_cfg(CFG_UNUSED, 16'($urandom));
  endtask

  function automatic int pick_coord(int base, int span);
    int v;
    case ($urandom_range(0, 5))
      0, 1: v = base + $urandom_range(0, 2 * span) - span;
      2:    v = $urandom_range(0, span + 20);
      3:    v = 1023 - $urandom_range(0, 40);
      default: v = $urandom_range(0, 1023);
    endcase
    return v < 0 ? 0 : (v > 1023 ? 1023 : v);
  endfunction

  function automatic logic [31:0] next_ms();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom;
      2: return $urandom_range(200, 3000);
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  task automatic random_gesture();
    int x0, y0, x, y, moves;
    if ($urandom_range(0, 6) == 0) begin
      send_beat(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      return;
    end
    x0 = pick_coord(160, SCREEN_WIDTH);
    y0 = pick_coord(120, SCREEN_HEIGHT);
    if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
    send_beat(1'b1, x0, y0, clock_ms);
    moves = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom_range(1, 10);
    repeat (moves) begin
      clock_ms += next_ms();
      if ($urandom_range(0, 7) == 0) begin
        x = x0; y = y0;
      end else begin
        x = pick_coord(x0, 150);
        y = pick_coord(y0, 150);
      end
      send_beat(1'b1, x, y, clock_ms);
    end
    clock_ms += next_ms();
    if ($urandom_range(0, 9) != 0)
      send_beat(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023), clock_ms);
    gestures++;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_touched = 1'b0; in_pos_x = '0; in_pos_y = '0; in_now_ms = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    beats_sent = 0; gestures = 0; burst_left = 0; clock_ms = 0; idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners, zero and wrapped duration, saturation, each direction
    send_beat(1'b0, 500, 500, 32'd7);
    send_beat(1'b1, 0, 0, 32'd0);
    send_beat(1'b1, 0, 0, 32'd0);
    send_beat(1'b1, 1023, 1023, 32'd0);
    send_beat(1'b1, 1023, 0, 32'd1);
    send_beat(1'b0, 0, 1023, 32'd1000);
    send_beat(1'b1, 160, 120, 32'hFFFF_FFF0);
    send_beat(1'b1, 160, 200, 32'd2);
    send_beat(1'b1, 160, 10, 32'd40);
    send_beat(1'b0, 160, 10, 32'd90);
    send_beat(1'b1, 300, 230, 32'd100);
    send_beat(1'b1, 100, 228, 32'd300);
    send_beat(1'b1, 319, 239, 32'd500);
    send_beat(1'b1, 319, 239, 32'd501);
    send_beat(1'b0, 5, 5, 32'hFFFF_FFFF);
    send_beat(1'b1, 319, 239, 32'd10);
    send_beat(1'b1, 1023, 500, 32'd12);
    send_beat(1'b0, 0, 0, 32'd12);

    while (beats_sent < 500) random_gesture();
    set_all(1, 1, 1, 1, 0, 1, 1);
    while (beats_sent < 900) random_gesture();
    set_all(1024, 1024, 1024, 1024, 65535, 65535, 65535);
    while (beats_sent < 1300) random_gesture();
    set_all($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 200),
            $urandom_range(1, 200), $urandom_range(0, 2048), $urandom_range(1, 1000),
            $urandom_range(1, 2000));
    while (beats_sent < 1920) random_gesture();

    quiesce();
    $display("sent %0d sample beats in %0d gestures over 4 register settings", beats_sent,
             gestures);
    $display("checked %0d result beats, %0d failures", event_count, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
